// ----- rtl/tdtf_pkg.sv -----
// shared types, register indexes and constants for the temperature display and trend filter
package tdtf_pkg;

  typedef logic [6:0] temp_t;
  typedef logic [7:0] byte_t;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT       = 3'd0,
    CFG_SNAP_BAND      = 3'd1,
    CFG_PULL_AMOUNT    = 3'd2,
    CFG_DISPLAY_PERIOD = 3'd3,
    CFG_TREND_PERIOD   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [6:0] setpoint;
    logic [5:0] snap_band;
    logic [4:0] pull_amount;
    logic [7:0] display_period;
    logic [7:0] trend_period;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    setpoint:       7'd50,
    snap_band:      6'd5,
    pull_amount:    5'd2,
    display_period: 8'd5,
    trend_period:   8'd1
  };

  localparam byte_t      TIMER_MAX        = 8'hff;
  localparam logic [3:0] MOVE_JUMP        = 4'd10;
  localparam logic [3:0] MOVE_MAX         = 4'd15;
  localparam logic [3:0] MOVE_QUIET       = 4'd7;
  localparam byte_t      BIG_MOVE         = 8'd2;
  localparam logic [3:0] PASSES_PER_TREND = 4'd10;

  // trend pass request from the top level
  typedef struct packed {
    logic  fire;
    logic  run;
    temp_t temp;
  } pass_req_t;

  // trend pass results for the output register
  typedef struct packed {
    logic  updated;
    byte_t trend;
    byte_t rate_sum;
  } pass_res_t;

endpackage

// ----- rtl/tdtf_in_if.sv -----
// request channel carrying one tick: temperature and running flag
interface tdtf_in_if;
  logic                valid;
  logic                ready;
  tdtf_pkg::temp_t     temperature;
  logic                running;

  modport source (output valid, output temperature, output running, input ready);
  modport sink   (input valid, input temperature, input running, output ready);
endinterface

// result channel carrying one output item per tick
interface tdtf_out_if;
  logic                valid;
  logic                ready;
  tdtf_pkg::byte_t     display_temperature;
  logic signed [7:0]   control_error;
  logic signed [7:0]   trend;
  logic signed [7:0]   rate_sum;
  logic                trend_updated;

  modport source (output valid, output display_temperature, output control_error,
                  output trend, output rate_sum, output trend_updated, input ready);
  modport sink   (input valid, input display_temperature, input control_error,
                  input trend, input rate_sum, input trend_updated, output ready);
endinterface

// ----- rtl/tdtf_display.sv -----
// display value calculation: pulls the measurement toward the setpoint inside the band
module tdtf_display (
  input  tdtf_pkg::temp_t temp_i,
  input  tdtf_pkg::cfg_t  cfg_i,
  output tdtf_pkg::byte_t display_o
);
  import tdtf_pkg::*;

  logic signed [9:0] t_s, sp_s, band_s, pull_s;
  logic signed [9:0] d_s, mag_s, lim_s, pop_s, res_s;
  logic              outside;

  // widen everything to signed values with headroom
  always_comb begin
    t_s    = {3'b000, temp_i};
    sp_s   = {3'b000, cfg_i.setpoint};
    band_s = {4'b0000, cfg_i.snap_band};
    pull_s = {5'b00000, cfg_i.pull_amount};
  end

  // band test and pull amount
  always_comb begin
    outside = (t_s >= sp_s + band_s) || (t_s <= sp_s - band_s);
    d_s     = sp_s - t_s;
    mag_s   = (d_s < 10'sd0) ? -d_s : d_s;
    lim_s   = band_s - pull_s;
    if (mag_s < pull_s) begin
      pop_s = mag_s;
    end else if (mag_s <= lim_s) begin
      pop_s = pull_s;
    end else begin
      pop_s = band_s - mag_s;
    end
    res_s = (d_s >= 10'sd0) ? (t_s + pop_s) : (t_s - pop_s);
  end

  assign display_o = outside ? {1'b0, temp_i} : res_s[7:0];

endmodule

// ----- rtl/tdtf_trend.sv -----
// trend pass: move counting, ten-pass trend and running sum over the delta window
module tdtf_trend #(
  parameter int WINDOW_LEN = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  tdtf_pkg::pass_req_t req_i,
  output tdtf_pkg::pass_res_t res_o
);
  import tdtf_pkg::*;

  logic [3:0] move_q, move_d;
  logic [3:0] pass_q, pass_d;
  byte_t      ref_q, ref_d;
  byte_t      prev_q, prev_d;
  byte_t      held_q, held_d;
  byte_t      sum_q, sum_d;
  logic       active_q, active_d;
  byte_t      win_q [WINDOW_LEN];
  byte_t      win_d [WINDOW_LEN];

  byte_t      t8, abs_diff, delta, oldest;
  logic [3:0] move_upd, pass_inc;
  logic       wrap;

  // move counter and pass counter
  always_comb begin
    t8       = {1'b0, req_i.temp};
    abs_diff = (t8 > ref_q) ? (t8 - ref_q) : (ref_q - t8);
    move_upd = ((abs_diff != 8'd0) && (move_q < MOVE_MAX)) ? (move_q + 4'd1) : move_q;
    if (abs_diff >= BIG_MOVE) begin
      move_upd = MOVE_JUMP;
    end
    pass_inc = pass_q + 4'd1;
    wrap     = (pass_inc >= PASSES_PER_TREND);
  end

  // trend on every tenth pass
  always_comb begin
    move_d = move_q;
    pass_d = pass_q;
    ref_d  = ref_q;
    held_d = held_q;
    prev_d = prev_q;
    if (req_i.fire) begin
      prev_d = t8;
      move_d = move_upd;
      pass_d = pass_inc;
      if (wrap) begin
        pass_d = 4'd0;
        move_d = 4'd0;
        if (move_upd <= MOVE_QUIET) begin
          held_d = 8'd0;
        end else begin
          held_d = t8 - ref_q;
          ref_d  = t8;
        end
      end
    end
  end

  // delta window shift with running sum, restarted after a stop
  always_comb begin
    delta    = t8 - prev_q;
    oldest   = active_q ? win_q[0] : 8'd0;
    active_d = active_q;
    sum_d    = sum_q;
    win_d    = win_q;
    if (req_i.fire) begin
      if (!req_i.run) begin
        active_d = 1'b0;
      end else begin
        active_d = 1'b1;
        sum_d    = (active_q ? sum_q : 8'd0) - oldest + delta;
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          win_d[i] = active_q ? win_q[i+1] : 8'd0;
        end
        win_d[WINDOW_LEN-1] = delta;
      end
    end
  end

  assign res_o.updated  = req_i.fire && wrap;
  assign res_o.trend    = held_d;
  assign res_o.rate_sum = active_d ? sum_d : 8'd0;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_q   <= 4'd0;
      pass_q   <= 4'd0;
      ref_q    <= 8'd0;
      prev_q   <= 8'd0;
      held_q   <= 8'd0;
      sum_q    <= 8'd0;
      active_q <= 1'b0;
    end else if (advance_i) begin
      move_q   <= move_d;
      pass_q   <= pass_d;
      ref_q    <= ref_d;
      prev_q   <= prev_d;
      held_q   <= held_d;
      sum_q    <= sum_d;
      active_q <= active_d;
    end
  end

  // window entries, cleared on the first running pass after a stop
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      win_q <= win_d;
    end
  end

endmodule

// ----- rtl/temperature_display_and_trend_filter.sv -----
// top level of the temperature display and trend filter
//
//  channel   direction  payload                                         transfer
//  in_ch_i   in         temperature, running                            valid && ready
//  out_ch_o  out        display_temperature, control_error, trend,      valid && ready
//                       rate_sum, trend_updated
//  cfg       in         cfg_idx_i, cfg_data_i                           cfg_we_i
//
// one tick per cycle while the output is not stalled; an accepted tick waits in the input
// register until the result register frees up; the input register and the result register
// each hold one tick, the step between them is timer update, display calc and one trend pass
// reset clears timers, counters, held values and window state; no clearing pass
// a stalled output holds its result while one more tick waits in the input register
module temperature_display_and_trend_filter #(
  parameter int WINDOW_LEN = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  tdtf_in_if.sink                            in_ch_i,
  tdtf_out_if.source                         out_ch_o,
  input  logic                               cfg_we_i,
  input  logic [tdtf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tdtf_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import tdtf_pkg::*;

  cfg_t      cfg_q;
  logic      s1_v_q;
  temp_t     s1_temp_q;
  logic      s1_run_q;
  logic      out_v_q;
  byte_t     disp_timer_q, disp_timer_d;
  byte_t     trend_timer_q, trend_timer_d;
  byte_t     held_disp_q;
  byte_t     disp_calc, disp_out, ctrl_err;
  logic      out_free, advance, disp_fire, trend_fire;
  pass_req_t pass_req;
  pass_res_t pass_res;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SETPOINT:       cfg_q.setpoint       <= cfg_data_i[6:0];
        CFG_SNAP_BAND:      cfg_q.snap_band      <= cfg_data_i[5:0];
        CFG_PULL_AMOUNT:    cfg_q.pull_amount    <= cfg_data_i[4:0];
        CFG_DISPLAY_PERIOD: cfg_q.display_period <= cfg_data_i;
        CFG_TREND_PERIOD:   cfg_q.trend_period   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake: the input register moves on whenever the result register frees up
  assign out_free      = !out_v_q || out_ch_o.ready;
  assign advance       = s1_v_q && out_free;
  assign in_ch_i.ready = !s1_v_q || out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_ch_i.ready) begin
      s1_v_q <= in_ch_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch_i.ready && in_ch_i.valid) begin
      s1_temp_q <= in_ch_i.temperature;
      s1_run_q  <= in_ch_i.running;
    end
  end

  // saturating interval timers
  always_comb begin
    disp_timer_d  = (disp_timer_q == TIMER_MAX) ? disp_timer_q : (disp_timer_q + 8'd1);
    trend_timer_d = (trend_timer_q == TIMER_MAX) ? trend_timer_q : (trend_timer_q + 8'd1);
    disp_fire     = (disp_timer_d >= cfg_q.display_period);
    trend_fire    = (trend_timer_d >= cfg_q.trend_period);
  end

  tdtf_display u_display (
    .temp_i    (s1_temp_q),
    .cfg_i     (cfg_q),
    .display_o (disp_calc)
  );

  assign pass_req.fire = advance && trend_fire;
  assign pass_req.run  = s1_run_q;
  assign pass_req.temp = s1_temp_q;

  tdtf_trend #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_trend (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .req_i     (pass_req),
    .res_o     (pass_res)
  );

  // display value and control error for this tick
  always_comb begin
    disp_out = disp_fire ? disp_calc : held_disp_q;
    ctrl_err = {1'b0, cfg_q.setpoint} - ({3'b000, cfg_q.pull_amount} - 8'd1)
               - {1'b0, s1_temp_q};
  end

  // timers, held display and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_timer_q  <= 8'd0;
      trend_timer_q <= 8'd0;
      held_disp_q   <= 8'd0;
      out_v_q       <= 1'b0;
    end else begin
      if (advance) begin
        disp_timer_q  <= disp_fire ? 8'd0 : disp_timer_d;
        trend_timer_q <= trend_fire ? 8'd0 : trend_timer_d;
        held_disp_q   <= disp_out;
      end
      if (out_free) begin
        out_v_q <= advance;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_ch_o.display_temperature <= disp_out;
      out_ch_o.control_error       <= ctrl_err;
      out_ch_o.trend               <= pass_res.trend;
      out_ch_o.rate_sum            <= pass_res.rate_sum;
      out_ch_o.trend_updated       <= pass_res.updated;
    end
  end

  assign out_ch_o.valid = out_v_q;

endmodule

// ----- rtl/tdtf_checker.sv -----
// port-level checks for the temperature display and trend filter, with its bind
module tdtf_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [7:0]        out_display_i,
  input logic [7:0]        out_error_i,
  input logic [7:0]        out_trend_i,
  input logic [7:0]        out_sum_i,
  input logic              out_updated_i
);
  logic       seen_q;
  logic [7:0] last_trend_q;

  // trend of the last delivered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= 1'b0;
      last_trend_q <= 8'd0;
    end else if (out_valid_i && out_ready_i) begin
      seen_q       <= 1'b1;
      last_trend_q <= out_trend_i;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_display_i)
      && $stable(out_error_i) && $stable(out_trend_i) && $stable(out_sum_i)
      && $stable(out_updated_i))
    else $error("stalled result changed");

  // an empty result register never blocks the request side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("request side blocked with empty result register");

  // the trend only changes on a result that flags a new trend
  a_trend_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_updated_i && seen_q |-> out_trend_i == last_trend_q)
    else $error("trend changed without an update");

  // a result does not appear without an earlier request
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_valid_i && in_ready_i) || $past(out_valid_i, 2)
      || $past(in_valid_i && in_ready_i, 2) || $past(!in_ready_i, 2))
    else $error("result appeared without an earlier request");

endmodule

bind temperature_display_and_trend_filter tdtf_checker u_tdtf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_ch_i.valid),
  .in_ready_i    (in_ch_i.ready),
  .out_valid_i   (out_ch_o.valid),
  .out_ready_i   (out_ch_o.ready),
  .out_display_i (out_ch_o.display_temperature),
  .out_error_i   (out_ch_o.control_error),
  .out_trend_i   (out_ch_o.trend),
  .out_sum_i     (out_ch_o.rate_sum),
  .out_updated_i (out_ch_o.trend_updated)
);
